[src/sfir_pkg.sv]
// ----------------------------------------------------------------------------
// sfir_pkg: shared types and constants for the stereo FIR filter
// Item layouts, tap cell data, control groups and fixed widths.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 16;
    localparam int INDEX_WIDTH  = 6;
    localparam int SHIFT_WIDTH  = 6;
    localparam int TAPS_DEFAULT = 64;

    localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = SHIFT_WIDTH'(18);

    // item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
        logic                           bypass;
        logic        [INDEX_WIDTH-1:0]  coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } out_item_t;

    // contents of one tap cell
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left;
        logic signed [SAMPLE_WIDTH-1:0] right;
        logic signed [COEF_WIDTH-1:0]   coef;
    } tap_t;

    typedef struct packed {
        logic                          shift_in;
        logic                          rotate;
        logic                          coef_we;
        logic       [INDEX_WIDTH-1:0]  coef_index;
        logic signed [COEF_WIDTH-1:0]  coef_value;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic accum;
        logic scale;
    } mac_ctrl_t;

endpackage

[src/stereo_fir_filter_with_bypass.sv]
// ----------------------------------------------------------------------------
// stereo_fir_filter_with_bypass: two-channel direct-form FIR with bypass
// Delay line and coefficients live in a ring of tap cells feeding one MAC.
// ----------------------------------------------------------------------------
// Input channel (src_valid / src_stall / src_item): a sample item
// (func = sample) shifts both samples into the ring and yields one result;
// a coefficient item writes the tap named by coef_index (ignored if out of
// range) and yields nothing. Coefficients must be written before use.
// Output channel (dst_valid / dst_stall / dst_item) carries the results.
// A filtered item rotates the ring once round, one tap per cycle through
// the shared multiply-accumulate, then passes the tail, scale and done
// states into the output register. A bypassed item goes from idle
// straight to done and shows its raw samples; a coefficient item is
// written on acceptance. One item is in flight at a time.
// The output register holds a result while dst_stall is high; a finished
// result waits in the done state and the next item is not taken until it can move on.
// Reset clears the delay line to zero and output_shift (cfg_data, written
// on cfg_we) to 18; coefficients are not cleared.
// ----------------------------------------------------------------------------
module stereo_fir_filter_with_bypass #(
    parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfir_pkg::SHIFT_WIDTH-1:0] cfg_data,
    input  logic                             src_valid,
    output logic                             src_stall,
    input  sfir_pkg::in_item_t               src_item,
    output logic                             dst_valid,
    input  logic                             dst_stall,
    output sfir_pkg::out_item_t              dst_item
);
    import sfir_pkg::*;

    localparam int CNT_W = $clog2(TAPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_TAIL  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       bypass_reg, bypass_next;
    logic [SHIFT_WIDTH-1:0]     shift_reg;
    logic                       dst_valid_reg, dst_valid_next;
    out_item_t                  dst_item_reg;
    logic                       src_acc;
    logic                       load_out;
    cell_ctrl_t                 cell_ctrl;
    mac_ctrl_t                  mac_ctrl;
    tap_t                       taps [TAPS];
    tap_t                       new_tap;
    logic signed [SAMPLE_WIDTH-1:0] sat_left, sat_right;

    assign src_stall = (state_reg != ST_IDLE);
    assign src_acc   = src_valid && !src_stall;
    assign load_out  = (state_reg == ST_DONE) && (!dst_valid_reg || !dst_stall);

    assign new_tap.left  = src_item.left_in;
    assign new_tap.right = src_item.right_in;
    assign new_tap.coef  = '0;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bypass_next = bypass_reg;

        cell_ctrl.shift_in   = 1'b0;
        cell_ctrl.rotate     = 1'b0;
        cell_ctrl.coef_we    = 1'b0;
        cell_ctrl.coef_index = src_item.coef_index;
        cell_ctrl.coef_value = src_item.coef_value;

        mac_ctrl.clear   = 1'b0;
        mac_ctrl.capture = 1'b0;
        mac_ctrl.accum   = 1'b0;
        mac_ctrl.scale   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (src_acc)
                begin
                    if (src_item.func == FUNC_COEF)
                    begin
                        cell_ctrl.coef_we = 1'b1;
                    end
                    else
                    begin
                        cell_ctrl.shift_in = 1'b1;
                        mac_ctrl.clear     = 1'b1;
                        bypass_next        = src_item.bypass;
                        cnt_next           = '0;
                        state_next         = src_item.bypass ? ST_DONE : ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                // take the head tap and bring the next one round
                cell_ctrl.rotate = 1'b1;
                mac_ctrl.capture = 1'b1;
                mac_ctrl.accum   = (cnt_reg != '0);
                cnt_next         = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                mac_ctrl.accum = 1'b1;
                state_next     = ST_SCALE;
            end
            ST_SCALE:
            begin
                mac_ctrl.scale = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < TAPS; i++)
        begin : g_cell
            sfir_cell #(
                .CELL_INDEX(i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .prev_tap ((i == 0) ? new_tap : taps[(i + TAPS - 1) % TAPS]),
                .next_tap (taps[(i + 1) % TAPS]),
                .tap      (taps[i])
            );
        end
    endgenerate

    sfir_mac #(
        .TAPS(TAPS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .head      (taps[0]),
        .shift     (shift_reg),
        .sat_left  (sat_left),
        .sat_right (sat_right)
    );

    always_comb
    begin
        dst_valid_next = dst_valid_reg;
        if (load_out)
            dst_valid_next = 1'b1;
        else if (!dst_stall)
            dst_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bypass_reg    <= 1'b0;
            shift_reg     <= SHIFT_RESET;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bypass_reg    <= bypass_next;
            dst_valid_reg <= dst_valid_next;
            if (cfg_we)
                shift_reg <= cfg_data;
        end
    end

    // the newest sample sits in the head cell again once the ring is back
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dst_item_reg.left_out  <= bypass_reg ? taps[0].left  : sat_left;
            dst_item_reg.right_out <= bypass_reg ? taps[0].right : sat_right;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

    a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
        (src_acc && src_item.func == FUNC_SAMPLE && !src_item.bypass)
        |=> (state_reg == ST_MAC && cnt_reg == '0))
        else $error("filtered item did not start the tap sweep at tap zero");

    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL) |-> $past(cnt_reg == CNT_LAST))
        else $error("tap sweep ended before a full turn of the ring");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && dst_valid_reg && dst_stall) |=> (state_reg == ST_DONE))
        else $error("finished item left while the output was stalled");

endmodule

[src/sfir_cell.sv]
// ----------------------------------------------------------------------------
// sfir_cell: one tap of the delay ring
// Holds a left/right sample pair and one coefficient. Shifts in from the
// previous cell on a new sample, rotates in from the next cell while the
// sum is formed, and takes a coefficient write addressed to its tap.
// ----------------------------------------------------------------------------
module sfir_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfir_pkg::cell_ctrl_t ctrl,
    input  sfir_pkg::tap_t      prev_tap,
    input  sfir_pkg::tap_t      next_tap,
    output sfir_pkg::tap_t      tap
);
    import sfir_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] left_reg,  left_next;
    logic signed [SAMPLE_WIDTH-1:0] right_reg, right_next;
    logic signed [COEF_WIDTH-1:0]   coef_reg,  coef_next;
    logic                           hit;

    assign hit = ctrl.coef_we && (32'(ctrl.coef_index) == CELL_INDEX);

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        coef_next  = coef_reg;
        if (ctrl.shift_in)
        begin
            left_next  = prev_tap.left;
            right_next = prev_tap.right;
        end
        else if (ctrl.rotate)
        begin
            left_next  = next_tap.left;
            right_next = next_tap.right;
            coef_next  = next_tap.coef;
        end
        else if (hit)
        begin
            coef_next = ctrl.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // coefficients hold no meaning until written
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign tap.left  = left_reg;
    assign tap.right = right_reg;
    assign tap.coef  = coef_reg;

endmodule

[src/sfir_mac.sv]
// ----------------------------------------------------------------------------
// sfir_mac: multiply-accumulate and output scaling for both channels
// Registers the products of the head cell, sums them, then shifts the sums
// right arithmetically and clamps them to the sample range.
// ----------------------------------------------------------------------------
module sfir_mac #(
    parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfir_pkg::mac_ctrl_t                   ctrl,
    input  sfir_pkg::tap_t                        head,
    input  logic [sfir_pkg::SHIFT_WIDTH-1:0]      shift,
    output logic signed [sfir_pkg::SAMPLE_WIDTH-1:0] sat_left,
    output logic signed [sfir_pkg::SAMPLE_WIDTH-1:0] sat_right
);
    import sfir_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic signed [ACC_W-1:0]  acc_l_reg,  acc_l_next;
    logic signed [ACC_W-1:0]  acc_r_reg,  acc_r_next;
    logic signed [ACC_W-1:0]  scaled_l_reg, scaled_r_reg;
    logic signed [ACC_W-1:0]  prod_l_ext, prod_r_ext;

    assign prod_l_ext = {{(ACC_W-PROD_W){prod_l_reg[PROD_W-1]}}, prod_l_reg};
    assign prod_r_ext = {{(ACC_W-PROD_W){prod_r_reg[PROD_W-1]}}, prod_r_reg};

    always_comb
    begin
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        if (ctrl.clear)
        begin
            acc_l_next = '0;
            acc_r_next = '0;
        end
        else if (ctrl.accum)
        begin
            acc_l_next = acc_l_reg + prod_l_ext;
            acc_r_next = acc_r_reg + prod_r_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            prod_l_reg <= $signed(head.left)  * $signed(head.coef);
            prod_r_reg <= $signed(head.right) * $signed(head.coef);
        end
        // a shift beyond the width leaves only the sign
        if (ctrl.scale)
        begin
            scaled_l_reg <= acc_l_reg >>> shift;
            scaled_r_reg <= acc_r_reg >>> shift;
        end
    end

    always_comb
    begin
        if (scaled_l_reg > SAT_HI)
            sat_left = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (scaled_l_reg < SAT_LO)
            sat_left = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            sat_left = scaled_l_reg[SAMPLE_WIDTH-1:0];

        if (scaled_r_reg > SAT_HI)
            sat_right = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (scaled_r_reg < SAT_LO)
            sat_right = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            sat_right = scaled_r_reg[SAMPLE_WIDTH-1:0];
    end

endmodule

[bench/tb_stereo_fir_filter_with_bypass.sv]
// ----------------------------------------------------------------------------
// tb_stereo_fir_filter_with_bypass: self-checking bench for the stereo FIR
// Loads all taps, runs a directed burst of extremes, then random traffic over
// several output shifts and idle patterns, predicting each filtered or
// bypassed result and checking it against the output channel in order.
// ----------------------------------------------------------------------------
module tb_stereo_fir_filter_with_bypass;

    import sfir_pkg::*;

    localparam int    TAPS     = TAPS_DEFAULT;
    localparam longint SAT_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = SAT_MAX[SAMPLE_WIDTH-1:0];
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = SAT_MIN[SAMPLE_WIDTH-1:0];

    // Mirror of the delay lines, tap table and shift; queues the filter output
    class stereo_fir_tracker;
        logic signed [SAMPLE_WIDTH-1:0] left_line[TAPS];
        logic signed [SAMPLE_WIDTH-1:0] right_line[TAPS];
        logic signed [COEF_WIDTH-1:0]   tap_coef[TAPS];
        int unsigned                    head;
        logic [SHIFT_WIDTH-1:0]         shift;
        out_item_t                      awaited[$];
        int                             mismatch_count;

        function void clear_state();
            for (int k = 0; k < TAPS; k++)
            begin
                left_line[k]  = '0;
                right_line[k] = '0;
                tap_coef[k]   = '0;
            end
            head           = 0;
            shift          = SHIFT_RESET;
            mismatch_count = 0;
            awaited.delete();
        endfunction

        function void set_shift(logic [SHIFT_WIDTH-1:0] value);
            shift = value;
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] scale_sum(longint acc);
            longint v;
            v = acc >>> shift;
            if (v > SAT_MAX)
                v = SAT_MAX;
            else if (v < SAT_MIN)
                v = SAT_MIN;
            return v[SAMPLE_WIDTH-1:0];
        endfunction

        function void take_item(in_item_t it);
            longint      acc_l;
            longint      acc_r;
            int unsigned p;
            out_item_t   res;
            if (it.func == FUNC_COEF)
            begin
                if (it.coef_index < TAPS)
                    tap_coef[it.coef_index] = it.coef_value;
                return;
            end
            left_line[head]  = it.left_in;
            right_line[head] = it.right_in;
            p    = head;
            head = (head + 1) % TAPS;
            if (it.bypass)
            begin
                res.left_out  = it.left_in;
                res.right_out = it.right_in;
                awaited.push_back(res);
                return;
            end
            acc_l = 0;
            acc_r = 0;
            // newest sample meets tap 0, walk back to the oldest
            for (int k = 0; k < TAPS; k++)
            begin
                acc_l += longint'(left_line[p]) * longint'(tap_coef[k]);
                acc_r += longint'(right_line[p]) * longint'(tap_coef[k]);
                p = (p == 0) ? TAPS - 1 : p - 1;
            end
            res.left_out  = scale_sum(acc_l);
            res.right_out = scale_sum(acc_r);
            awaited.push_back(res);
        endfunction

        task report(string field, longint got, longint want);
            mismatch_count++;
            $display("mismatch %0d: %s got %0d, want %0d", mismatch_count, field, got, want);
        endtask

        task match_output(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected item, left_out", got.left_out, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.left_out !== want.left_out)
                report("left_out", got.left_out, want.left_out);
            if (got.right_out !== want.right_out)
                report("right_out", got.right_out, want.right_out);
        endtask

        task flush_leftovers();
            out_item_t want;
            while (awaited.size() != 0)
            begin
                want = awaited.pop_front();
                report("missing item, left_out", 0, want.left_out);
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [SHIFT_WIDTH-1:0] cfg_data;
    logic                   src_valid;
    logic                   src_stall;
    in_item_t               src_item;
    logic                   dst_valid;
    logic                   dst_stall = 1'b0;
    out_item_t              dst_item;

    int                src_idle_pct = 0;
    int                dst_stall_pct = 0;
    stereo_fir_tracker tracker;

    stereo_fir_filter_with_bypass uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output side: take results and drive random back-pressure
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && dst_valid === 1'b1 && !dst_stall)
            tracker.match_output(dst_item);
        dst_stall <= (rst_n === 1'b1) && ($urandom_range(99) < dst_stall_pct);
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    // Called just after a rising edge; returns at the edge that accepts the item
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        tracker.take_item(it);
    endtask

    task automatic wait_drained();
        while (tracker.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Block must be idle: drain, let a last coefficient item finish, then write
    task automatic write_shift(input logic [SHIFT_WIDTH-1:0] value);
        src_valid <= 1'b0;
        wait_drained();
        repeat (TAPS + 16) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_shift(value);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int a;
        case ($urandom_range(9))
            0, 1, 2: return SAMPLE_WIDTH'($urandom);
            3, 4, 5:
            begin
                a = 1 << $urandom_range(2, 16);
                return SAMPLE_WIDTH'(int'($urandom_range(2 * a)) - a);
            end
            6: return S_MAX;
            7: return S_MIN;
            8: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic in_item_t coef_item(int idx, int value);
        in_item_t it;
        it            = '0;
        it.left_in    = SAMPLE_WIDTH'($urandom);
        it.right_in   = SAMPLE_WIDTH'($urandom);
        it.bypass     = 1'($urandom);
        it.func       = FUNC_COEF;
        it.coef_index = idx[INDEX_WIDTH-1:0];
        it.coef_value = value[COEF_WIDTH-1:0];
        return it;
    endfunction

    function automatic in_item_t sample_item(logic signed [SAMPLE_WIDTH-1:0] l,
                                             logic signed [SAMPLE_WIDTH-1:0] r,
                                             logic bp);
        in_item_t it;
        it            = '0;
        it.func       = FUNC_SAMPLE;
        it.left_in    = l;
        it.right_in   = r;
        it.bypass     = bp;
        it.coef_index = INDEX_WIDTH'($urandom);
        it.coef_value = COEF_WIDTH'($urandom);
        return it;
    endfunction

    function automatic int pick_coef();
        if ($urandom_range(1) == 0)
            return int'($urandom_range(512)) - 256;
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
        in_item_t it;
        src_idle_pct  = idle_pct;
        dst_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            // hold off now and then until every result is back
            if ($urandom_range(99) < 2)
            begin
                src_valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(3) == 0)
                it = coef_item($urandom_range(TAPS - 1), pick_coef());
            else
                it = sample_item(pick_sample(), pick_sample(), $urandom_range(4) == 0);
            send_item(it);
        end
    endtask

    initial
    begin
        tracker = new;
        tracker.clear_state();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= SHIFT_RESET;
        src_valid <= 1'b0;
        src_item  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass needs no taps, so it may come before the table is loaded
        send_item(sample_item(S_MAX, S_MIN, 1'b1));
        send_item(sample_item(S_MIN, S_MAX, 1'b1));

        // load every tap before any filtered item
        for (int k = 0; k < TAPS; k++)
            send_item(coef_item(k, pick_coef()));
        send_item(coef_item(0, 32767));
        send_item(coef_item(TAPS - 1, -32768));

        send_item(sample_item(S_MAX, S_MIN, 1'b0));
        send_item(sample_item(S_MIN, S_MAX, 1'b0));
        send_item(sample_item('0, '0, 1'b0));
        send_item(sample_item('1, 24'sd1, 1'b0));
        send_item(sample_item(S_MAX, S_MAX, 1'b1));
        send_item(sample_item(S_MAX, S_MAX, 1'b0));
        send_item(sample_item(S_MIN, S_MIN, 1'b0));
        // coefficient item with every ignored field set
        begin
            in_item_t noisy;
            noisy          = coef_item(1, -1);
            noisy.left_in  = '1;
            noisy.right_in = '1;
            noisy.bypass   = 1'b1;
            send_item(noisy);
        end
        send_item(sample_item(S_MIN, S_MAX, 1'b0));

        // shift of zero drives the sums into saturation
        write_shift(SHIFT_WIDTH'(0));
        send_item(sample_item(S_MAX, S_MIN, 1'b0));
        send_item(sample_item(24'sd3, -24'sd3, 1'b0));
        write_shift(SHIFT_WIDTH'(63));
        send_item(sample_item(S_MIN, S_MAX, 1'b0));
        send_item(sample_item(24'sd1, -24'sd1, 1'b0));

        write_shift(SHIFT_RESET);
        run_phase(150, 0, 0);
        write_shift(SHIFT_WIDTH'(0));
        run_phase(150, 63, 0);
        write_shift(SHIFT_WIDTH'(40));
        run_phase(150, 0, 63);
        write_shift(SHIFT_WIDTH'(63));
        run_phase(100, 32, 32);
        write_shift(SHIFT_WIDTH'(41));
        run_phase(100, 0, 0);
        write_shift(SHIFT_WIDTH'(12));
        run_phase(150, 63, 0);
        write_shift(SHIFT_WIDTH'(24));
        run_phase(150, 0, 63);
        write_shift(SHIFT_WIDTH'(18));
        run_phase(100, 32, 32);

        src_valid <= 1'b0;
        wait_drained();
        repeat (TAPS + 16) @(posedge clk);
        tracker.flush_leftovers();
        if (tracker.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
